/* rtl/radial_cosine_wave_pixel_defines.svh */
// Assertion macros shared by the radial cosine wave pixel RTL
`ifndef RADIAL_COSINE_WAVE_PIXEL_DEFINES_SVH
`define RADIAL_COSINE_WAVE_PIXEL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCWP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RCWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rcwp_pkg.sv */
// Package: types, constants and cosine table helpers for the ripple pixel block
package rcwp_pkg;

    // field widths
    localparam int FRAME_W = 16;
    localparam int COORD_W = 12;
    localparam int GRAY_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_FPS          = 3'd2,
        CFG_WAVE_LENGTH  = 3'd3,
        CFG_AMPLITUDE    = 3'd4,
        CFG_PERIOD_MS    = 3'd5
    } t_cfg_idx;

    // pi/2 in Q62
    localparam logic [63:0] HALF_PI_Q62 = 64'd7244019458077122842;

    // (a*b) >> 62
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // cos(th) in Q62 by Taylor series, th in Q62 within a quarter turn
    function automatic logic [63:0] cos_series(input logic [63:0] th);
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        th2  = mul_q62(th, th);
        term = 64'd1 << 62;
        sum  = term;
        for (int k = 1; k <= 14; k++) begin
            term = mul_q62(term, th2) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Q1.15 table entry from a quarter-wave angle and a sign
    function automatic logic [15:0] q15_entry(input logic [63:0] th, input logic neg);
        logic [63:0] mag;
        mag = (cos_series(th) + (64'd1 << 46)) >> 47;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return neg ? (16'd0 - mag[15:0]) : mag[15:0];
    endfunction

endpackage

/* rtl/rcwp_cfg_if.sv */
// Configuration write channel
interface rcwp_cfg_if;
    import rcwp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rcwp_pix_if.sv */
// Pixel request channel
interface rcwp_pix_if;
    import rcwp_pkg::*;
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_index;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    modport source (output valid, frame_index, pixel_x, pixel_y, input ready);
    modport sink   (input valid, frame_index, pixel_x, pixel_y, output ready);
endinterface

/* rtl/rcwp_gray_if.sv */
// Gray value result channel
interface rcwp_gray_if;
    import rcwp_pkg::*;
    logic              valid;
    logic              ready;
    logic [GRAY_W-1:0] gray_value;
    modport source (output valid, gray_value, input ready);
    modport sink   (input valid, gray_value, output ready);
endinterface

/* rtl/rcwp_div.sv */
// Pipelined restoring divider, one quotient bit per stage
module rcwp_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);
    // stage s holds the dividend bits still to come, with quotient bits shifted in
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_step
        logic [NUM_W-1:0] w_num;
        logic [DEN_W-1:0] w_rem;
        logic [DEN_W:0]   w_trial;
        logic             w_ge;
        logic [NUM_W-1:0] n_num;
        logic [DEN_W-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_num = i_num;
            assign w_rem = i_rem;
        end else begin : g_next
            assign w_num = r_num[s-1];
            assign w_rem = r_rem[s-1];
        end

        // bring down one bit, subtract if it fits
        always_comb begin
            w_trial = {w_rem, w_num[NUM_W-1]};
            w_ge    = w_trial >= {1'b0, i_den};
            n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, i_den}) : w_trial[DEN_W-1:0];
            n_num   = {w_num[NUM_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s] <= n_num;
                r_rem[s] <= n_rem;
            end
        end
    end

    assign o_quo = r_num[NUM_W-1];
    assign o_rem = r_rem[NUM_W-1];
endmodule

/* rtl/rcwp_sqrt.sv */
// Pipelined integer square root, one root bit per stage
module rcwp_sqrt #(
    parameter int IN_W = 34
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_val,
    output logic [IN_W/2-1:0] o_root
);
    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [IN_W-1:0]   r_val  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        logic [IN_W-1:0]   w_val;
        logic [REM_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [REM_W+1:0]  w_acc;
        logic [REM_W+1:0]  w_trial;
        logic              w_ge;
        logic [IN_W-1:0]   n_val;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (s == 0) begin : g_first
            assign w_val  = i_val;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_val  = r_val[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_root = r_root[s-1];
        end

        // bring down two bits, try root*4+1
        always_comb begin
            w_acc   = {w_rem, w_val[IN_W-1 -: 2]};
            w_trial = (REM_W + 2)'({w_root, 2'b01});
            w_ge    = w_acc >= w_trial;
            n_rem   = w_ge ? REM_W'(w_acc - w_trial) : w_acc[REM_W-1:0];
            n_root  = {w_root[ROOT_W-2:0], w_ge};
            n_val   = {w_val[IN_W-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[s]  <= n_val;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule

/* rtl/radial_cosine_wave_pixel.sv */
// Radial cosine ripple pixel generator: top level
//
// One gray value per pixel request, 127 + A*cos(2*pi*(t/T - d/L)) truncated. The block is a
// single 53-stage pipeline that takes a new word every cycle and gives one word per cycle.
// The length is set by the bit-per-stage units: 17 square-root stages, 29 stages dividing the
// distance by the wavelength, and on the time path 26 + 16 divider stages for the frame
// phase. The whole pipeline advances together and holds only while a finished word waits
// at the output. Configuration writes are taken at once and must be made while no request
// is in flight.
module radial_cosine_wave_pixel #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcwp_cfg_if.sink     i_cfg,
    rcwp_pix_if.sink     i_pix,
    rcwp_gray_if.source  o_gray
);
    import rcwp_pkg::*;

    localparam int IDX_W    = $clog2(COS_TABLE_DEPTH);
    localparam int SQRT_IN_W = 34;
    localparam int ROOT_W   = SQRT_IN_W / 2;
    localparam int MOD_W    = 26;
    localparam int DEN_W    = 24;
    localparam int FRAC_W   = 16;
    localparam int SP_NUM_W = ROOT_W + 12;
    localparam int WL_W     = 13;
    // stage where each path ends
    localparam int ST_PT    = 1 + MOD_W + FRAC_W;
    localparam int ST_PS    = 3 + ROOT_W + SP_NUM_W;
    localparam int PT_DLY   = ST_PS - ST_PT;
    localparam int NSTAGE   = ST_PS + 4;
    localparam logic [16:0] DEPTH_V = 17'(COS_TABLE_DEPTH);

    // configuration registers
    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [7:0]  r_fps;
    logic [12:0] r_wave_length;
    logic [6:0]  r_amplitude;
    logic [15:0] r_period_ms;
    // derived divisors
    logic [DEN_W-1:0] r_den;
    logic [WL_W-1:0]  r_wl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
            r_fps          <= 8'd30;
            r_wave_length  <= 13'd32;
            r_amplitude    <= 7'd64;
            r_period_ms    <= 16'd1000;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[12:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[12:0];
                CFG_FPS:          r_fps          <= i_cfg.data[7:0];
                CFG_WAVE_LENGTH:  r_wave_length  <= i_cfg.data[12:0];
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg.data[6:0];
                CFG_PERIOD_MS:    r_period_ms    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // zero rate, period or wavelength count as one
    logic [DEN_W-1:0] n_den;
    logic [WL_W-1:0]  n_wl;
    always_comb begin
        n_den = DEN_W'((r_fps == 8'd0) ? 8'd1 : r_fps)
              * DEN_W'((r_period_ms == 16'd0) ? 16'd1 : r_period_ms);
        n_wl  = (r_wave_length == 13'd0) ? 13'd1 : r_wave_length;
    end

    always_ff @(posedge i_clk) begin
        r_den <= n_den;
        r_wl  <= n_wl;
    end

    // pipeline enable and valid bits
    logic [NSTAGE:1] r_vld;
    logic            w_en;

    assign w_en        = !r_vld[NSTAGE] || o_gray.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTAGE-1:1], i_pix.valid};
        end
    end

    // stage 1: offsets from centre doubled, frame time scaled
    logic signed [14:0] r_dx;
    logic signed [14:0] r_dy;
    logic [MOD_W-1:0]   r_tprod;
    logic signed [14:0] n_dx;
    logic signed [14:0] n_dy;

    always_comb begin
        n_dx = $signed({2'b00, i_pix.pixel_x, 1'b0}) - $signed({2'b00, r_frame_width})
             + 15'sd1;
        n_dy = $signed({2'b00, i_pix.pixel_y, 1'b0}) - $signed({2'b00, r_frame_height})
             + 15'sd1;
    end

    // stage 2: squares; stage 3: scaled sum of squares
    logic [25:0] r_sqx;
    logic [25:0] r_sqy;
    logic [32:0] r_v;
    logic signed [29:0] w_sqx;
    logic signed [29:0] w_sqy;

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_tprod <= MOD_W'(i_pix.frame_index) * MOD_W'(1000);
            r_sqx   <= w_sqx[25:0];
            r_sqy   <= w_sqy[25:0];
            r_v     <= {27'(r_sqx) + 27'(r_sqy), 6'b000000};
        end
    end

    // distance in Q13.4
    logic [ROOT_W-1:0] w_d16;
    rcwp_sqrt #(.IN_W(SQRT_IN_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  ({1'b0, r_v}),
        .o_root (w_d16)
    );

    // spatial phase = d16*4096 / L, low 16 bits
    logic [SP_NUM_W-1:0] w_sp_quo;
    logic [WL_W-1:0]     w_sp_rem;
    rcwp_div #(.NUM_W(SP_NUM_W), .DEN_W(WL_W)) u_div_space (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({w_d16, 12'd0}),
        .i_rem ('0),
        .i_den (r_wl),
        .o_quo (w_sp_quo),
        .o_rem (w_sp_rem)
    );

    // temporal phase: frame*1000 mod D, then fraction of D in 16 bits
    logic [MOD_W-1:0]  w_mod_quo;
    logic [DEN_W-1:0]  w_mod_rem;
    logic [FRAC_W-1:0] w_pt;
    logic [DEN_W-1:0]  w_frac_rem;

    rcwp_div #(.NUM_W(MOD_W), .DEN_W(DEN_W)) u_div_mod (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_tprod),
        .i_rem ('0),
        .i_den (r_den),
        .o_quo (w_mod_quo),
        .o_rem (w_mod_rem)
    );

    rcwp_div #(.NUM_W(FRAC_W), .DEN_W(DEN_W)) u_div_frac (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ('0),
        .i_rem (w_mod_rem),
        .i_den (r_den),
        .o_quo (w_pt),
        .o_rem (w_frac_rem)
    );

    // delay temporal phase to line up with the spatial phase
    logic [FRAC_W-1:0] r_ptd [PT_DLY];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ptd[0] <= w_pt;
            for (int k = 1; k < PT_DLY; k++) begin
                r_ptd[k] <= r_ptd[k-1];
            end
        end
    end

    // cosine table, Q1.15
    logic [15:0] w_cos_rom [COS_TABLE_DEPTH];
    for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
        localparam int unsigned QV   = 4 * g;
        localparam int unsigned QUAD = QV / COS_TABLE_DEPTH;
        localparam int unsigned RV   = QV % COS_TABLE_DEPTH;
        localparam int unsigned RR   = (QUAD == 1 || QUAD == 3) ? COS_TABLE_DEPTH - RV : RV;
        localparam logic [63:0] TH   = (HALF_PI_Q62 / COS_TABLE_DEPTH) * 64'(RR)
                                     + ((HALF_PI_Q62 % COS_TABLE_DEPTH) * 64'(RR))
                                     / COS_TABLE_DEPTH;
        localparam logic [15:0] ENT  = q15_entry(TH, QUAD == 1 || QUAD == 2);
        assign w_cos_rom[g] = ENT;
    end

    // phase to table index, lookup, scale, offset
    logic [15:0]        w_ph;
    logic [32:0]        w_phm;
    logic [IDX_W-1:0]   r_idx;
    logic signed [15:0] r_cos;
    logic signed [22:0] r_prod;
    logic [GRAY_W-1:0]  r_gray;
    logic signed [23:0] w_acc;

    always_comb begin
        w_ph  = r_ptd[PT_DLY-1] - w_sp_quo[15:0];
        w_phm = 33'(w_ph) * 33'(DEPTH_V);
        w_acc = 24'sd4161536 + 24'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx  <= w_phm[16 +: IDX_W];
            r_cos  <= $signed(w_cos_rom[r_idx]);
            r_prod <= $signed({1'b0, r_amplitude}) * r_cos;
            r_gray <= w_acc[22:15];
        end
    end

    assign o_gray.valid      = r_vld[NSTAGE];
    assign o_gray.gray_value = r_gray;

`include "radial_cosine_wave_pixel_defines.svh"

    `RCWP_ASSERT_NOW(a_ready_only_on_stall, i_clk, i_rst_n, !i_pix.ready, o_gray.valid, "input held back with no word waiting")
    `RCWP_ASSERT_NOW(a_gray_range, i_clk, i_rst_n, o_gray.valid, o_gray.gray_value != 8'd255, "gray value out of range")
    `RCWP_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, o_gray.valid && !o_gray.ready, $stable(r_vld), "pipeline moved while stalled")

endmodule
